// ===== hdl/rtrs_pkg.sv =====
package rtrs_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int SUM_WIDTH   = 32;
	localparam int LANE_W      = 16;
	localparam int COEF_FRAC   = 14;
	localparam int NUM_REGS    = 5;
	localparam int CFG_W       = 3 * LANE_W;
	localparam int IDX_W       = 3;
	localparam int D_W         = COORD_WIDTH + 1;
	localparam int ACC_W       = 48;
	localparam int DIFF_W      = 24;
	localparam int MPL_W       = 24;
	localparam int CNT_W       = 5;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW0  = 3'd0,
		REG_ROW1  = 3'd1,
		REG_ROW2  = 3'd2,
		REG_TRANS = 3'd3,
		REG_PIVOT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROUND,
		ST_SQUARE,
		ST_SQRT,
		ST_ACCUM
	} state_t;

endpackage

// ===== hdl/rtrs_if.sv =====
interface rtrs_pair_if;
	import rtrs_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic signed [COORD_WIDTH-1:0] target_z;
	logic signed [COORD_WIDTH-1:0] source_x;
	logic signed [COORD_WIDTH-1:0] source_y;
	logic signed [COORD_WIDTH-1:0] source_z;
	logic last_pair;
	modport source (output valid, target_x, target_y, target_z, source_x, source_y,
		source_z, last_pair, input ready);
	modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
		source_z, last_pair, output ready);
endinterface

interface rtrs_sum_if;
	import rtrs_pkg::*;
	logic valid;
	logic ready;
	logic [SUM_WIDTH-1:0] error_sum;
	logic saturated;
	modport source (output valid, error_sum, saturated, input ready);
	modport sink (input valid, error_sum, saturated, output ready);
endinterface

// ===== hdl/rigid_transform_residual_sum_core.sv =====
// channel   | dir | payload                                   | handshake
// pair_in   | in  | target xyz, source xyz, last_pair         | valid/ready
// sum_out   | out | error_sum, saturated                      | valid/ready
// cfg       | in  | cfg_we, cfg_index, cfg_data               | write on cfg_we
//
// each item is accepted, then for each row three of the nine coefficient products
// run on the bit-serial multiply-accumulate unit, followed by rounding and a 24-bit
// square; the square root recurrence and the accumulate step close the item.
// arst_n clears the sequencer, the running sum, the result register and the
// registers to the identity transform. a last item waits in the accumulate step
// while an earlier result is still held in the result register.
module rigid_transform_residual_sum_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rtrs_pkg::IDX_W-1:0] cfg_index,
	input  logic [rtrs_pkg::CFG_W-1:0] cfg_data,
	rtrs_pair_if.sink                 pair_in,
	rtrs_sum_if.source                sum_out
);
	import rtrs_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0] row0_q, row1_q, row2_q, trans_q, pivot_q;

	logic signed [COORD_WIDTH-1:0] tgt_q [3];
	logic signed [D_W-1:0]         d_q [3];
	logic                          last_q;

	logic [1:0]       row_q, col_q;
	logic [CNT_W-1:0] bit_q;
	logic [MPL_W-1:0] mplier_q;
	logic [ACC_W-1:0] mcand_q, acc_q, sq_q, res_q, sbit_q;

	logic [SUM_WIDTH-1:0] sum_q, out_sum_q;
	logic                 ovf_q, out_sat_q, out_valid_q;

	logic accept, out_free;

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LANE_W - 1);
	localparam logic [CNT_W-1:0] SQR_LAST = CNT_W'(MPL_W - 1);

	function automatic logic [LANE_W-1:0] lane_of(input logic [CFG_W-1:0] r,
		input logic [1:0] k);
		logic [LANE_W-1:0] v;
		case (k)
			2'd0:    v = r[LANE_W-1:0];
			2'd1:    v = r[2*LANE_W-1:LANE_W];
			default: v = r[3*LANE_W-1:2*LANE_W];
		endcase
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] row_of(input logic [1:0] r,
		input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] c);
		logic [CFG_W-1:0] v;
		case (r)
			2'd0:    v = a;
			2'd1:    v = b;
			default: v = c;
		endcase
		return v;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q  <= CFG_W'(1) << COEF_FRAC;
			row1_q  <= CFG_W'(1) << (COEF_FRAC + LANE_W);
			row2_q  <= CFG_W'(1) << (COEF_FRAC + 2 * LANE_W);
			trans_q <= '0;
			pivot_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW0:  row0_q  <= cfg_data;
				REG_ROW1:  row1_q  <= cfg_data;
				REG_ROW2:  row2_q  <= cfg_data;
				REG_TRANS: trans_q <= cfg_data;
				REG_PIVOT: pivot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshakes
	assign out_free = !out_valid_q || sum_out.ready;
	assign accept   = pair_in.valid && pair_in.ready;

	// outputs of the sequencer
	always_comb begin
		pair_in.ready = (state_q == ST_IDLE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (pair_in.valid) state_d = ST_MUL;
			ST_MUL:    if (bit_q == MUL_LAST && col_q == 2'd2) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_SQUARE;
			ST_SQUARE: if (bit_q == SQR_LAST) state_d = (row_q == 2'd2) ? ST_SQRT : ST_MUL;
			ST_SQRT:   if (sbit_q[0]) state_d = ST_ACCUM;
			ST_ACCUM:  if (!last_q || out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// pivot-relative source of the incoming item
	logic signed [D_W-1:0] d_in [3];
	always_comb begin
		d_in[0] = D_W'(pair_in.source_x) - D_W'($signed(lane_of(pivot_q, 2'd0)));
		d_in[1] = D_W'(pair_in.source_y) - D_W'($signed(lane_of(pivot_q, 2'd1)));
		d_in[2] = D_W'(pair_in.source_z) - D_W'($signed(lane_of(pivot_q, 2'd2)));
	end

	// shared shift-add unit: one multiplier bit a cycle, sign bit subtracts when multiplying
	logic [ACC_W-1:0] addend, acc_next, sq_next;
	always_comb begin
		addend = mplier_q[0] ? mcand_q : '0;
		if (state_q == ST_MUL && bit_q == MUL_LAST) addend = -addend;
		acc_next = acc_q + addend;
		sq_next  = sq_q + addend;
	end

	// row rounding, translation, pivot and target difference
	logic signed [ACC_W-1:0]  rnd_full;
	logic signed [DIFF_W-1:0] diff;
	logic [MPL_W-1:0]         mag;
	always_comb begin
		rnd_full = ($signed(acc_q) + ACC_W'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
		diff = rnd_full[DIFF_W-1:0]
			+ DIFF_W'($signed(lane_of(trans_q, row_q)))
			+ DIFF_W'($signed(lane_of(pivot_q, row_q)))
			- DIFF_W'(tgt_q[row_q]);
		mag = diff[DIFF_W-1] ? MPL_W'(-diff) : MPL_W'(diff);
	end

	// square root step
	logic [ACC_W-1:0] trial;
	always_comb trial = res_q + sbit_q;

	// saturating accumulation
	logic [SUM_WIDTH-1:0] step_len, sum_new;
	logic                 ovf_new;
	always_comb begin
		step_len = res_q[SUM_WIDTH-1:0];
		if (ovf_q || step_len > SUM_MAX - sum_q) begin
			sum_new = SUM_MAX;
			ovf_new = 1'b1;
		end else begin
			sum_new = sum_q + step_len;
			ovf_new = 1'b0;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                                        out_valid_q <= 1'b0;
		else if (state_q == ST_ACCUM && last_q && out_free) out_valid_q <= 1'b1;
		else if (sum_out.ready)                             out_valid_q <= 1'b0;
	end

	// datapath and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			bit_q     <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			tgt_q     <= '{default: '0};
			d_q       <= '{default: '0};
			last_q    <= 1'b0;
			mplier_q  <= '0;
			mcand_q   <= '0;
			acc_q     <= '0;
			sq_q      <= '0;
			res_q     <= '0;
			sbit_q    <= '0;
			out_sum_q <= '0;
			out_sat_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tgt_q[0] <= pair_in.target_x;
						tgt_q[1] <= pair_in.target_y;
						tgt_q[2] <= pair_in.target_z;
						d_q      <= d_in;
						last_q   <= pair_in.last_pair;
						row_q    <= '0;
						col_q    <= '0;
						bit_q    <= '0;
						acc_q    <= '0;
						sq_q     <= '0;
						mplier_q <= MPL_W'(lane_of(row0_q, 2'd0));
						mcand_q  <= ACC_W'(d_in[0]);
					end
				end
				ST_MUL: begin
					acc_q    <= acc_next;
					mplier_q <= mplier_q >> 1;
					mcand_q  <= mcand_q << 1;
					bit_q    <= bit_q + 1'b1;
					if (bit_q == MUL_LAST) begin
						bit_q <= '0;
						if (col_q != 2'd2) begin
							col_q    <= col_q + 1'b1;
							mplier_q <= MPL_W'(lane_of(row_of(row_q, row0_q, row1_q, row2_q),
								col_q + 1'b1));
							mcand_q  <= ACC_W'(d_q[col_q + 1'b1]);
						end
					end
				end
				ST_ROUND: begin
					mplier_q <= mag;
					mcand_q  <= ACC_W'(mag);
					bit_q    <= '0;
				end
				ST_SQUARE: begin
					sq_q     <= sq_next;
					mplier_q <= mplier_q >> 1;
					mcand_q  <= mcand_q << 1;
					bit_q    <= bit_q + 1'b1;
					if (bit_q == SQR_LAST) begin
						bit_q <= '0;
						if (row_q != 2'd2) begin
							row_q    <= row_q + 1'b1;
							col_q    <= '0;
							acc_q    <= '0;
							mplier_q <= MPL_W'(lane_of(row_of(row_q + 1'b1, row0_q, row1_q,
								row2_q), 2'd0));
							mcand_q  <= ACC_W'(d_q[0]);
						end else begin
							res_q  <= '0;
							sbit_q <= ACC_W'(1) << (ACC_W - 2);
						end
					end
				end
				ST_SQRT: begin
					if (sq_q >= trial) begin
						sq_q  <= sq_q - trial;
						res_q <= (res_q >> 1) + sbit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
				ST_ACCUM: begin
					if (!last_q) begin
						sum_q <= sum_new;
						ovf_q <= ovf_new;
					end else if (out_free) begin
						out_sum_q <= sum_new;
						out_sat_q <= ovf_new;
						sum_q     <= '0;
						ovf_q     <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign sum_out.valid     = out_valid_q;
	assign sum_out.error_sum = out_sum_q;
	assign sum_out.saturated = out_sat_q;

`ifndef ASSERT_OFF
	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> sum_q == SUM_MAX)
		else $error("overflow set with unclamped sum");
	a_sqrt_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> $onehot(sbit_q))
		else $error("square root bit not one-hot");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MUL && row_q == 2'd0 && col_q == 2'd0)
		else $error("accepted item did not start multiply");
`endif

endmodule
